### hw/rtl/lclt_pkg.sv
`timescale 1ns / 1ps
package lclt_pkg;

  localparam int ID_BITS    = 10;
  localparam int MAX_CHAIN  = 64;
  localparam int TABLE_SIZE = 1 << ID_BITS;
  localparam int CNT_BITS   = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LEADER = 2'd1;
  localparam logic [1:0] OP_CHAIN  = 2'd2;

  typedef logic [ID_BITS-1:0] id_t;

  typedef struct packed {
    logic valid;
    id_t  parent;
    id_t  depth;
    id_t  leader;
  } entry_t;

  typedef struct packed {
    logic   en;
    id_t    addr;
    entry_t data;
  } tbl_wr_t;

endpackage

### hw/rtl/lclt_table.sv
`timescale 1ns / 1ps
module lclt_table import lclt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    rd_en,
  input  id_t     rd_addr,
  output entry_t  rd_data,
  input  tbl_wr_t wr,
  output logic    clearing
);

  entry_t mem [TABLE_SIZE];
  id_t    clr_addr;
  entry_t clr_word;

  always_comb begin
    clr_word        = '0;
    clr_word.valid  = (clr_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // sweep owns the write port until the clear is done
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= clr_word;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/longest_chain_leader_tracker.sv
`timescale 1ns / 1ps
// Insert reads the parent and new id words, writes the new entry, then walks up from the
// parent, setting the new id as leader while the old leader is shallower; leader query reads
// block then leader. One command at a time; busy is low again by the cycle of the last result.
// Throughput is set by the single read port of the block table, one access per step.
// Reset (rst, synchronous): a clearing pass sweeps every table entry, busy stays high.
// The receiver cannot stall: each result is shown for one cycle with done high.
module longest_chain_leader_tracker import lclt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          opcode,
  input  logic [ID_BITS-1:0]  block_id,
  input  logic [ID_BITS-1:0]  parent_id,
  input  logic [CNT_BITS-1:0] max_count,
  output logic                done,
  output logic                status,
  output logic [ID_BITS-1:0]  value,
  output logic [ID_BITS-1:0]  tip_depth,
  output logic                last
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RD0     = 3'd1;
  localparam logic [2:0] ST_INS_ID  = 3'd2;
  localparam logic [2:0] ST_W_CMP   = 3'd3;
  localparam logic [2:0] ST_W_PAR   = 3'd4;
  localparam logic [2:0] ST_LQ      = 3'd5;
  localparam logic [2:0] ST_CH_EMIT = 3'd6;
  localparam logic [2:0] ST_CH_WAIT = 3'd7;

  logic [2:0]          state;
  logic [1:0]          op;
  id_t                 id;
  id_t                 par;
  logic [CNT_BITS-1:0] maxc;
  entry_t              pword;
  id_t                 p;
  id_t                 d;
  logic [CNT_BITS-1:0] n;

  logic    rd_en;
  id_t     rd_addr;
  entry_t  rd_data;
  tbl_wr_t wr;
  logic    clearing;
  logic    chain_end;
  entry_t  lead_word;

  lclt_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr       (wr),
    .clearing (clearing)
  );

  assign busy      = clearing || (state != ST_IDLE);
  assign chain_end = (p == '0) || ((n + 1'b1) >= maxc);

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr        = '0;
    lead_word = pword;
    lead_word.leader = id;
    unique case (state)
      ST_IDLE: begin
        rd_en   = start && !clearing;
        rd_addr = (opcode == OP_INSERT) ? parent_id : block_id;
      end
      ST_RD0: begin
        rd_en   = 1'b1;
        rd_addr = (op == OP_INSERT) ? id : rd_data.leader;
      end
      ST_INS_ID: begin
        // parent word in pword, new id word in rd_data
        if (pword.valid && !rd_data.valid) begin
          wr.en          = 1'b1;
          wr.addr        = id;
          wr.data.valid  = 1'b1;
          wr.data.parent = par;
          wr.data.depth  = pword.depth + 1'b1;
          wr.data.leader = id;
          rd_en          = 1'b1;
          rd_addr        = pword.leader;
        end
      end
      ST_W_CMP: begin
        if (rd_data.depth < d) begin
          wr.en   = 1'b1;
          wr.addr = p;
          wr.data = lead_word;
          rd_en   = (p != '0);
          rd_addr = pword.parent;
        end
      end
      ST_W_PAR: begin
        rd_en   = 1'b1;
        rd_addr = rd_data.leader;
      end
      ST_LQ: begin
      end
      ST_CH_EMIT: begin
        rd_en   = !chain_end;
        rd_addr = p;
      end
      ST_CH_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start && !clearing) begin
            op   <= opcode;
            id   <= block_id;
            par  <= parent_id;
            maxc <= (max_count > CNT_BITS'(MAX_CHAIN)) ? CNT_BITS'(MAX_CHAIN) : max_count;
            if (opcode == OP_INSERT || opcode == OP_LEADER || opcode == OP_CHAIN) begin
              state <= ST_RD0;
            end else begin
              done      <= 1'b1;
              status    <= 1'b1;
              value     <= '0;
              tip_depth <= '0;
              last      <= 1'b1;
            end
          end
        end
        ST_RD0: begin
          priority if (op == OP_INSERT) begin
            pword <= rd_data;
            state <= ST_INS_ID;
          end else if (!rd_data.valid || (op == OP_CHAIN && maxc == '0)) begin
            done      <= 1'b1;
            status    <= 1'b1;
            value     <= '0;
            tip_depth <= '0;
            last      <= 1'b1;
            state     <= ST_IDLE;
          end else if (op == OP_LEADER) begin
            p     <= rd_data.leader;
            state <= ST_LQ;
          end else begin
            p     <= rd_data.leader;
            n     <= '0;
            state <= ST_CH_EMIT;
          end
        end
        ST_INS_ID: begin
          if (pword.valid && !rd_data.valid) begin
            d     <= pword.depth + 1'b1;
            p     <= par;
            state <= ST_W_CMP;
          end else begin
            done      <= 1'b1;
            status    <= 1'b1;
            value     <= '0;
            tip_depth <= '0;
            last      <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_W_CMP: begin
          if (rd_data.depth >= d || p == '0) begin
            done      <= 1'b1;
            status    <= 1'b0;
            value     <= d;
            tip_depth <= '0;
            last      <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            p     <= pword.parent;
            state <= ST_W_PAR;
          end
        end
        ST_W_PAR: begin
          pword <= rd_data;
          state <= ST_W_CMP;
        end
        ST_LQ: begin
          done      <= 1'b1;
          status    <= 1'b0;
          value     <= p;
          tip_depth <= rd_data.depth;
          last      <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_CH_EMIT: begin
          done      <= 1'b1;
          status    <= 1'b0;
          value     <= p;
          tip_depth <= '0;
          last      <= chain_end;
          n         <= n + 1'b1;
          state     <= chain_end ? ST_IDLE : ST_CH_WAIT;
        end
        ST_CH_WAIT: begin
          p     <= rd_data.parent;
          state <= ST_CH_EMIT;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
